// ===== design/bptl_pkg.sv =====
// shared types and constants for the bilinear property table lookup
package bptl_pkg;

   localparam int NCOL  = 13;
   localparam int NPROP = 11;
   localparam int VW    = 48;
   localparam int RW    = 40;
   localparam int CW    = 7;

   typedef logic signed [VW-1:0] value_type;
   typedef logic [RW-1:0] recip_type;
   typedef logic [CW-1:0] count_type;

   typedef enum logic [2:0] {
      REG_P_START   = 3'd0,
      REG_H_START   = 3'd1,
      REG_P_RECIP   = 3'd2,
      REG_H_RECIP   = 3'd3,
      REG_P_COUNT   = 3'd4,
      REG_H_COUNT   = 3'd5
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_IDXMUL, ST_IDXHI, ST_IDX, ST_ADDR, ST_BASE0, ST_BASE1,
      ST_FRACMUL, ST_FRAC, ST_CORNER, ST_INTERP, ST_MIX, ST_SUM, ST_EMIT
   } state_type;

   localparam logic [0:0] FUNC_WRITE = 1'b0;
   localparam logic [0:0] FUNC_QUERY = 1'b1;

   // store column for each emitted property
   function automatic logic [3:0] prop_column(input logic [3:0] k);
      logic [3:0] c;
      begin
         case (k)
            4'd0: c = 4'd2;
            4'd1: c = 4'd6;
            4'd2: c = 4'd3;
            4'd3: c = 4'd5;
            4'd4: c = 4'd4;
            4'd5: c = 4'd7;
            4'd6: c = 4'd8;
            4'd7: c = 4'd9;
            4'd8: c = 4'd10;
            4'd9: c = 4'd11;
            default: c = 4'd12;
         endcase
         return c;
      end
   endfunction

endpackage

// ===== design/bilinear_property_table_lookup.sv =====
// top level: node store, cell search and bilinear interpolation
//
// channel  direction  handshake          payload
// req      in         start & !busy      req_func req_entry_index req_column
//                                        req_write_value req_pressure req_enthalpy
// rsp      out        rsp_valid strobe   rsp_property_id rsp_property_value rsp_last
// csr      in         apb write          pwdata to register paddr/8
//
// a write word does not raise busy; a query holds busy through setup for
// the index multiply, cell address, two base reads and the fraction multiply, then
// for each of the 11 properties: 4 corner reads from the node store and
// 4 interpolation steps; a property word is shown after each, the last in the first
// idle cycle, so the next word can be taken while it is shown.
// reset is synchronous; clears control state, starts and reciprocals, sets counts to 2; store is undefined.
// results are strobed for one cycle each; the receiver cannot stall.
module bilinear_property_table_lookup #(
   parameter int MAX_PRESSURE_POINTS = 64,
   parameter int MAX_ENTHALPY_POINTS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_func,
   input  logic [11:0]               req_entry_index,
   input  logic [3:0]                req_column,
   input  logic signed [47:0]        req_write_value,
   input  logic signed [47:0]        req_pressure,
   input  logic signed [47:0]        req_enthalpy,
   output logic                      rsp_valid,
   output logic [3:0]                rsp_property_id,
   output logic signed [47:0]        rsp_property_value,
   output logic                      rsp_last,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [5:0]                paddr,
   input  logic [63:0]               pwdata,
   output logic [63:0]               prdata,
   output logic                      pready
);
   import bptl_pkg::*;

   localparam int NNODE = MAX_PRESSURE_POINTS * MAX_ENTHALPY_POINTS;
   localparam int DEPTH = NNODE * NCOL;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW_W  = $clog2(NNODE + 1);
   localparam int PIW   = $clog2(MAX_PRESSURE_POINTS);
   localparam int HIW   = $clog2(MAX_ENTHALPY_POINTS);

   // configuration registers
   value_type p_start_ff, h_start_ff;
   recip_type p_recip_ff, h_recip_ff;
   count_type p_count_ff, h_count_ff;
   logic      csr_wr;
   reg_type   csr_reg;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_reg = reg_type'(paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_start_ff <= '0;
         h_start_ff <= '0;
         p_recip_ff <= '0;
         h_recip_ff <= '0;
         p_count_ff <= CW'(2);
         h_count_ff <= CW'(2);
      end else if (csr_wr && paddr[2:0] == 3'd0) begin
         unique case (csr_reg)
            REG_P_START: p_start_ff <= pwdata[47:0];
            REG_H_START: h_start_ff <= pwdata[47:0];
            REG_P_RECIP: p_recip_ff <= pwdata[39:0];
            REG_H_RECIP: h_recip_ff <= pwdata[39:0];
            REG_P_COUNT: p_count_ff <= pwdata[6:0];
            REG_H_COUNT: h_count_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2:0] == 3'd0) begin
         unique case (csr_reg)
            REG_P_START: prdata = {{16{p_start_ff[47]}}, p_start_ff};
            REG_H_START: prdata = {{16{h_start_ff[47]}}, h_start_ff};
            REG_P_RECIP: prdata = {24'd0, p_recip_ff};
            REG_H_RECIP: prdata = {24'd0, h_recip_ff};
            REG_P_COUNT: prdata = {57'd0, p_count_ff};
            REG_H_COUNT: prdata = {57'd0, h_count_ff};
            default:     prdata = '0;
         endcase
      end
   end

   // clamped counts
   logic [8:0] pc, hc;
   always_comb begin
      pc = (p_count_ff < CW'(2)) ? 9'd2 :
           ({2'd0, p_count_ff} > 9'(MAX_PRESSURE_POINTS)) ? 9'(MAX_PRESSURE_POINTS)
                                                          : {2'd0, p_count_ff};
      hc = (h_count_ff < CW'(2)) ? 9'd2 :
           ({2'd0, h_count_ff} > 9'(MAX_ENTHALPY_POINTS)) ? 9'(MAX_ENTHALPY_POINTS)
                                                          : {2'd0, h_count_ff};
   end

   // node store
   logic [47:0] mem [DEPTH];
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic [47:0]   rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= req_write_value;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   logic accept;
   assign accept = start && !busy;
   assign wr_en  = accept && req_func == FUNC_WRITE && req_column < 4'(NCOL)
                   && 32'(req_entry_index) < NNODE;
   assign wr_addr = AW'({17'd0, req_entry_index} * 29'(NCOL) + 29'(req_column));

   // query state
   state_type state_ff, state_in;
   value_type p_ff, h_ff;
   logic [47:0] dp_ff, dh_ff;        // differences, used only when positive
   logic        dp_pos_ff, dh_pos_ff;
   logic [87:0] prodp_ff, prodh_ff;  // difference times reciprocal
   logic [43:0] prodp_hi_ff, prodh_hi_ff;
   logic [PIW:0] ip_ff;
   logic [HIW:0] ih_ff;
   logic [NW_W+1:0] nw_ff;
   logic [16:0] fy_ff, fx_ff;
   value_type base_ff;
   logic [3:0] k_ff;
   logic [1:0] corner_ff;
   logic signed [49:0] vnw_ff, vne_ff, vsw_ff, vse_ff;
   logic signed [50:0] inner_ff, dsw_ff, t_ff;
   logic signed [51:0] v_ff;
   logic below_ff;

   // half products of a 48x40 multiply split in two 48x20 halves
   logic [67:0] mul_lo_p, mul_lo_h, mul_hi_p, mul_hi_h;
   assign mul_lo_p = dp_ff * p_recip_ff[19:0];
   assign mul_hi_p = dp_ff * p_recip_ff[39:20];
   assign mul_lo_h = dh_ff * h_recip_ff[19:0];
   assign mul_hi_h = dh_ff * h_recip_ff[39:20];

   function automatic logic signed [50:0] scale(input logic signed [50:0] a,
                                                input logic [16:0] f);
      logic signed [68:0] pr;
      begin
         pr = a * $signed({1'b0, f});
         return pr[66:16];
      end
   endfunction

   logic signed [48:0] diff_p, diff_h;
   logic [AW+3:0] corner_addr;
   logic [NW_W+1:0] corner_node;
   logic [1:0] corner_sel;

   // the corner loop reads one corner ahead of the one it captures
   assign corner_sel = (state_ff == ST_CORNER) ? corner_ff + 2'd1 : corner_ff;

   always_comb begin
      case (corner_sel)
         2'd0: corner_node = nw_ff;
         2'd1: corner_node = nw_ff + (NW_W+2)'(1);
         2'd2: corner_node = nw_ff + (NW_W+2)'(hc);
         default: corner_node = nw_ff + (NW_W+2)'(hc) + (NW_W+2)'(1);
      endcase
      corner_addr = (AW+4)'(corner_node) * (AW+4)'(NCOL) + (AW+4)'(prop_column(k_ff));
   end

   always_comb begin
      state_in = state_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      unique case (state_ff)
         ST_IDLE:   if (accept && req_func == FUNC_QUERY) state_in = ST_IDXMUL;
         ST_IDXMUL: state_in = ST_IDXHI;
         ST_IDXHI:  state_in = ST_IDX;
         ST_IDX:    state_in = ST_ADDR;
         ST_ADDR: begin
            rd_en    = 1'b1;
            rd_addr  = AW'((AW+4)'(nw_ff) * (AW+4)'(NCOL));
            state_in = ST_BASE0;
         end
         ST_BASE0: begin
            rd_en    = 1'b1;
            rd_addr  = AW'((AW+4)'(nw_ff) * (AW+4)'(NCOL) + (AW+4)'(1));
            state_in = ST_BASE1;
         end
         ST_BASE1:   state_in = ST_FRACMUL;
         ST_FRACMUL: state_in = ST_FRAC;
         ST_FRAC: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(corner_addr);
            state_in = ST_CORNER;
         end
         ST_CORNER: begin
            if (corner_ff != 2'd3) begin
               rd_en   = 1'b1;
               rd_addr = AW'(corner_addr);
            end else begin
               state_in = ST_INTERP;
            end
         end
         ST_INTERP: state_in = ST_MIX;
         ST_MIX:    state_in = ST_SUM;
         ST_SUM:    state_in = ST_EMIT;
         ST_EMIT:   state_in = (k_ff == 4'(NPROP - 1)) ? ST_IDLE : ST_FRAC;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign diff_p = $signed({p_ff[47], p_ff}) - $signed({base_ff[47], base_ff});
   assign diff_h = $signed({h_ff[47], h_ff}) - $signed({rd_data_ff[47], rd_data_ff});

   logic [63:0] idxp_raw, idxh_raw;
   assign idxp_raw = prodp_hi_ff[43:0] == '0 ? 64'(prodp_ff[87:48]) : '1;
   assign idxh_raw = prodh_hi_ff[43:0] == '0 ? 64'(prodh_ff[87:48]) : '1;

   function automatic logic [16:0] frac_of(input logic pos, input logic [87:0] pr);
      begin
         if (!pos) return '0;
         if (pr[87:64] != '0 || pr[63:32] > 32'd65536) return 17'd65536;
         return pr[48:32];
      end
   endfunction

   logic signed [52:0] v_sat;
   assign v_sat = v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= state_ff == ST_EMIT;
      end
   end

   logic signed [48:0] d_p0, d_h0;
   assign d_p0 = $signed({req_pressure[47], req_pressure})
                 - $signed({p_start_ff[47], p_start_ff});
   assign d_h0 = $signed({req_enthalpy[47], req_enthalpy})
                 - $signed({h_start_ff[47], h_start_ff});

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            p_ff      <= req_pressure;
            h_ff      <= req_enthalpy;
            below_ff  <= req_pressure < p_start_ff;
            dp_pos_ff <= d_p0 > 0;
            dh_pos_ff <= d_h0 > 0;
            dp_ff     <= d_p0[47:0];
            dh_ff     <= d_h0[47:0];
         end
         ST_IDXMUL, ST_FRACMUL: begin
            prodp_ff <= {mul_hi_p + 68'(mul_lo_p[67:20]), mul_lo_p[19:0]};
            prodh_ff <= {mul_hi_h + 68'(mul_lo_h[67:20]), mul_lo_h[19:0]};
            prodp_hi_ff <= '0;
            prodh_hi_ff <= '0;
         end
         ST_IDXHI: begin
            if (!dp_pos_ff || 64'(idxp_raw) > 64'(pc - 9'd2))
               ip_ff <= (PIW+1)'(dp_pos_ff ? pc - 9'd2 : 9'd0);
            else ip_ff <= (PIW+1)'(idxp_raw);
            if (!dh_pos_ff || 64'(idxh_raw) > 64'(hc - 9'd2))
               ih_ff <= (HIW+1)'(dh_pos_ff ? hc - 9'd2 : 9'd0);
            else ih_ff <= (HIW+1)'(idxh_raw);
         end
         ST_IDX: begin
            nw_ff <= (NW_W+2)'(ip_ff) * (NW_W+2)'(hc) + (NW_W+2)'(ih_ff);
            k_ff  <= '0;
            corner_ff <= '0;
         end
         ST_BASE0: begin
            base_ff   <= rd_data_ff;
         end
         ST_FRAC: ;
         default: ;
      endcase
      if (state_ff == ST_BASE1) begin
         dp_pos_ff <= diff_p > 0;
         dh_pos_ff <= diff_h > 0;
         dp_ff     <= diff_p[47:0];
         dh_ff     <= diff_h[47:0];
      end
      if (state_ff == ST_FRAC && corner_ff == 2'd0 && k_ff == 4'd0) begin
         fy_ff <= frac_of(dp_pos_ff, prodp_ff);
         fx_ff <= frac_of(dh_pos_ff, prodh_ff);
      end
      if (state_ff == ST_FRAC || state_ff == ST_CORNER) begin
         if (state_ff == ST_CORNER) begin
            case (corner_ff)
               2'd0: vnw_ff <= 50'($signed(rd_data_ff));
               2'd1: vne_ff <= 50'($signed(rd_data_ff));
               2'd2: vsw_ff <= 50'($signed(rd_data_ff));
               default: vse_ff <= 50'($signed(rd_data_ff));
            endcase
            corner_ff <= corner_ff + 2'd1;
         end
      end
      if (state_ff == ST_INTERP) begin
         inner_ff <= scale(51'(vse_ff) - 51'(vsw_ff) - 51'(vne_ff) + 51'(vnw_ff), fy_ff);
         dsw_ff   <= scale(51'(vsw_ff) - 51'(vnw_ff), fy_ff);
      end
      if (state_ff == ST_MIX) t_ff <= 51'(vne_ff) - 51'(vnw_ff) + inner_ff;
      if (state_ff == ST_SUM) v_ff <= 52'(vnw_ff) + 52'(dsw_ff) + 52'(scale(t_ff, fx_ff));
      if (state_ff == ST_EMIT) begin
         rsp_property_id <= k_ff;
         rsp_last        <= k_ff == 4'(NPROP - 1);
         if (k_ff == 4'd0 && below_ff) rsp_property_value <= 48'sd65536;
         else if (v_sat > 53'sh7FFFFFFFFFFF) rsp_property_value <= 48'h7FFFFFFFFFFF;
         else if (v_sat < -53'sh800000000000) rsp_property_value <= 48'h800000000000;
         else rsp_property_value <= v_sat[47:0];
         k_ff <= k_ff + 4'd1;
      end
   end

   assign busy = state_ff != ST_IDLE;

   a_emit_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid) else $error("run continues after last");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result while idle");
   a_corner: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INTERP |-> corner_ff == 2'd0) else $error("corner count off");
endmodule

// ===== dv/bptl_checker.sv =====
// checker: watches the channels, predicts the property runs and compares them
`timescale 1ns / 100ps
module bptl_checker
   import bptl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_func,
   input  logic [11:0]        req_entry_index,
   input  logic [3:0]         req_column,
   input  logic signed [47:0] req_write_value,
   input  logic signed [47:0] req_pressure,
   input  logic signed [47:0] req_enthalpy,
   input  logic               rsp_valid,
   input  logic [3:0]         rsp_property_id,
   input  logic signed [47:0] rsp_property_value,
   input  logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [5:0]         paddr,
   input  logic [63:0]        pwdata,
   input  logic               pready,
   output int                 errors,
   output int                 pending
);

   localparam int MAXP = 64;
   localparam int MAXH = 64;
   localparam longint ONE = 65536;
   localparam longint VMAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint VMIN = -64'sh8000_0000_0000;
   localparam logic [3:0] PROP_COL [0:NPROP-1] = '{4'd2, 4'd6, 4'd3, 4'd5, 4'd4, 4'd7,
                                                   4'd8, 4'd9, 4'd10, 4'd11, 4'd12};

   typedef struct {
      logic [3:0] id;
      value_type  val;
      logic       last;
   } prop_word_type;

   value_type  node_mem [0:MAXP*MAXH*NCOL-1];
   value_type  p_start, h_start;
   recip_type  p_recip, h_recip;
   count_type  p_count, h_count;
   prop_word_type prop_q[$];

   function automatic longint eff_count(count_type c, int lim);
      if (c < 2) return 2;
      return (c > lim) ? lim : c;
   endfunction

   function automatic longint cell_of(longint v, longint st, recip_type r, longint cnt);
      longint d, idx;
      logic [127:0] prod;
      d = v - st;
      if (d <= 0) return 0;
      prod = {64'd0, d} * {88'd0, r};
      idx = longint'(prod >> 48);
      return (idx > cnt - 2) ? cnt - 2 : idx;
   endfunction

   function automatic longint frac_of(longint v, longint base, recip_type r);
      longint d, f;
      logic [127:0] prod;
      d = v - base;
      if (d <= 0) return 0;
      prod = {64'd0, d} * {88'd0, r};
      if (prod[127:64] != 0) return ONE;
      f = longint'(prod[63:32]);
      return (f > ONE) ? ONE : f;
   endfunction

   function automatic longint scl(longint a, longint f);
      logic signed [127:0] pr;
      pr = a;
      pr = pr * f;
      pr = pr >>> 16;
      return longint'(pr);
   endfunction

   task automatic predict_run(input value_type pq, input value_type hq);
      longint pc, hc, ip, ih, nw, ne, sw, se, fy, fx, vnw, vne, vsw, vse, t, v, p, h;
      prop_word_type w;
      p  = pq;
      h  = hq;
      pc = eff_count(p_count, MAXP);
      hc = eff_count(h_count, MAXH);
      ip = cell_of(p, p_start, p_recip, pc);
      ih = cell_of(h, h_start, h_recip, hc);
      nw = ip * hc + ih;
      ne = nw + 1;
      sw = nw + hc;
      se = sw + 1;
      fy = frac_of(p, node_mem[nw*NCOL], p_recip);
      fx = frac_of(h, node_mem[nw*NCOL+1], h_recip);
      for (int k = 0; k < NPROP; k++) begin
         vnw = node_mem[nw*NCOL+PROP_COL[k]];
         vne = node_mem[ne*NCOL+PROP_COL[k]];
         vsw = node_mem[sw*NCOL+PROP_COL[k]];
         vse = node_mem[se*NCOL+PROP_COL[k]];
         t = vne - vnw + scl(vse - vsw - vne + vnw, fy);
         v = vnw + scl(vsw - vnw, fy) + scl(t, fx);
         if (v > VMAX) v = VMAX;
         if (v < VMIN) v = VMIN;
         if (k == 0 && p < longint'(p_start)) v = ONE;
         w.id   = k[3:0];
         w.val  = v[47:0];
         w.last = (k == NPROP - 1);
         prop_q.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      prop_word_type exp_w;
      if (reset) begin
         p_start = '0;
         h_start = '0;
         p_recip = '0;
         h_recip = '0;
         p_count = 7'd2;
         h_count = 7'd2;
         prop_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_type'(paddr[5:3]))
               REG_P_START: p_start = pwdata[47:0];
               REG_H_START: h_start = pwdata[47:0];
               REG_P_RECIP: p_recip = pwdata[39:0];
               REG_H_RECIP: h_recip = pwdata[39:0];
               REG_P_COUNT: p_count = pwdata[6:0];
               REG_H_COUNT: h_count = pwdata[6:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (prop_q.size() == 0) begin
               $error("property word with none expected: id %0d value %0d",
                      rsp_property_id, rsp_property_value);
               errors++;
            end else begin
               exp_w = prop_q.pop_front();
               if (rsp_property_id !== exp_w.id) begin
                  $error("property_id: expected %0d, actual %0d", exp_w.id, rsp_property_id);
                  errors++;
               end
               if (rsp_property_value !== exp_w.val) begin
                  $error("property_value: expected %0d, actual %0d",
                         exp_w.val, rsp_property_value);
                  errors++;
               end
               if (rsp_last !== exp_w.last) begin
                  $error("last: expected %0d, actual %0d", exp_w.last, rsp_last);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            if (req_func == FUNC_QUERY) begin
               predict_run(req_pressure, req_enthalpy);
            end else if (req_column < NCOL && req_entry_index < MAXP * MAXH) begin
               node_mem[req_entry_index*NCOL+req_column] = req_write_value;
            end
         end
      end
      pending = prop_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: stimulus, register setup, watchdog and verdict
`timescale 1ns / 100ps
module tb_top;
   import bptl_pkg::*;

   localparam int WATCHDOG = 4000;
   localparam int SETTLE   = 120;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_func = FUNC_WRITE;
   logic [11:0]       req_entry_index = '0;
   logic [3:0]        req_column = '0;
   logic signed [47:0] req_write_value = '0;
   logic signed [47:0] req_pressure = '0;
   logic signed [47:0] req_enthalpy = '0;
   logic              rsp_valid;
   logic [3:0]        rsp_property_id;
   logic signed [47:0] rsp_property_value;
   logic              rsp_last;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [5:0]        paddr = '0;
   logic [63:0]       pwdata = '0;
   logic [63:0]       prdata;
   logic              pready;
   int                errors, pending;
   int                quiet_cycles = 0;

   bit     idling = 1'b1;
   longint ps, hs, pstep, hstep, pce, hce;

   always #6 clock = ~clock;

   bilinear_property_table_lookup DUT (.*);

   bptl_checker checker_i (.*);

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic logic [47:0] rand48();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [47:0] rand_prop();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return 48'h7FFF_FFFF_FFFF;
      if (sel == 1) return 48'h8000_0000_0000;
      if (sel < 10) return rand48();
      return 48'(longint'($urandom_range(0, 2**21)) - 2**20);
   endfunction

   task automatic gap_maybe();
      if (idling && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic send_word(input logic f, input logic [11:0] ent, input logic [3:0] col,
                            input logic [47:0] wv, input logic [47:0] p, input logic [47:0] h);
      start           <= 1'b1;
      req_func        <= f;
      req_entry_index <= ent;
      req_column      <= col;
      req_write_value <= wv;
      req_pressure    <= p;
      req_enthalpy    <= h;
      do @(negedge clock); while (busy);
      @(posedge clock);
      gap_maybe();
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      @(posedge clock);
   endtask

   task automatic csr_write(input reg_type r, input logic [63:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 3'b000};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input longint p0, input longint h0, input logic [39:0] pr,
                            input logic [39:0] hr, input logic [6:0] pcr,
                            input logic [6:0] hcr);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_write(REG_P_START, 64'(p0));
      csr_write(REG_H_START, 64'(h0));
      csr_write(REG_P_RECIP, 64'(pr));
      csr_write(REG_H_RECIP, 64'(hr));
      csr_write(REG_P_COUNT, 64'(pcr));
      csr_write(REG_H_COUNT, 64'(hcr));
      ps  = p0;
      hs  = h0;
      pce = (pcr < 2) ? 2 : (pcr > 64) ? 64 : pcr;
      hce = (hcr < 2) ? 2 : (hcr > 64) ? 64 : hcr;
      @(posedge clock);
   endtask

   task automatic fill_nodes(input int first, input int num);
      logic [47:0] v;
      for (int n = first; n < first + num; n++) begin
         for (int c = 0; c < NCOL; c++) begin
            if (c == 0) v = 48'(ps + longint'(n / hce) * pstep);
            else if (c == 1) v = 48'(hs + longint'(n % hce) * hstep);
            else v = rand_prop();
            send_word(FUNC_WRITE, 12'(n), 4'(c), v, rand48(), rand48());
         end
      end
   endtask

   task automatic fill_table();
      fill_nodes(0, int'(pce * hce));
   endtask

   task automatic query_mix(input int nq);
      longint p, h;
      int kind;
      for (int i = 0; i < nq; i++) begin
         if (i == nq / 2) drain();
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            send_word(FUNC_WRITE, 12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15)),
                      rand48(), rand48(), rand48());
         end else if (kind == 1) begin
            send_word(FUNC_QUERY, 12'($urandom), 4'($urandom), rand48(), rand48(), rand48());
         end else begin
            p = ps + longint'($urandom_range(0, pce)) * pstep
                + longint'($urandom_range(0, 2 * pstep)) - pstep;
            h = hs + longint'($urandom_range(0, hce)) * hstep
                + longint'($urandom_range(0, 2 * hstep)) - hstep;
            send_word(FUNC_QUERY, 12'($urandom), 4'($urandom), rand48(), 48'(p), 48'(h));
         end
      end
   endtask

   initial begin
      logic [47:0] edge_vals [0:3];
      edge_vals = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0, 48'hFFFF_FFFF_FFFF};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero reciprocals, 2 x 2 grid
      ps = 0; hs = 0; pstep = 1; hstep = 1; pce = 2; hce = 2;
      fill_table();
      for (int i = 0; i < 4; i++)
         send_word(FUNC_QUERY, 12'hFFF, 4'hF, 48'h0, edge_vals[i], edge_vals[3-i]);
      send_word(FUNC_WRITE, 12'hFFF, 4'd13, 48'h7FFF_FFFF_FFFF, 48'h0, 48'h0);
      send_word(FUNC_WRITE, 12'h000, 4'd15, 48'h8000_0000_0000, 48'h0, 48'h0);

      // extreme starts, largest reciprocals, counts clamped from 127 and 0
      // pressure lands on the first or the last row only, enthalpy on column 0
      pstep = 1; hstep = 1;
      configure(-64'sh8000_0000_0000, 64'sh7FFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
                40'hFF_FFFF_FFFF, 7'd127, 7'd0);
      fill_nodes(124, 4);
      for (int i = 0; i < 16; i++)
         send_word(FUNC_QUERY, 12'h0, 4'h0, 48'h0,
                   (i < 4) ? edge_vals[i] : (rand48() & 48'h7FFF_FFFF_FFFF),
                   (i < 4) ? edge_vals[i] : rand48());

      for (int ph = 0; ph < 3; ph++) begin
         pstep = longint'($urandom_range(512, 2**30));
         hstep = longint'($urandom_range(512, 2**30));
         if (ph == 2) idling = 1'b0;
         configure(longint'($urandom_range(0, 2**30)) * 512 - 2**38,
                   longint'($urandom_range(0, 2**30)) * 512 - 2**38,
                   40'((64'd1 << 48) / pstep), 40'((64'd1 << 48) / hstep),
                   (ph == 0) ? 7'd1 : (ph == 1) ? 7'd2 : 7'd3,
                   (ph == 1) ? 7'd3 : 7'd2);
         fill_table();
         query_mix(32);
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
